>>> rtl/lu_linear_system_solver_top_defines.svh
// Assertion macros for the LU solver block.
// LU_ASSERT checks a property while reset is low; LU_ASSERT_RST also
// checks it during reset.
`ifndef LU_LINEAR_SYSTEM_SOLVER_TOP_DEFINES_SVH
`define LU_LINEAR_SYSTEM_SOLVER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define LU_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LU_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LU_ASSERT(label, clk, rst, prop, msg)
`define LU_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

>>> rtl/lu_solve_pkg.sv
// ----------------------------------------------------------------------------
// lu_solve_pkg
// Types, sizes and helper functions for the Crout LU solver.
// ----------------------------------------------------------------------------
`default_nettype none
package lu_solve_pkg;

  localparam int MAX_ORDER = 16;
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int ROW_W     = 4;
  localparam int COL_W     = 5;
  localparam int ORDER_W   = 5;
  localparam int IDX_W     = $clog2(MAX_ORDER);
  localparam int CNT_W     = IDX_W + 1;
  localparam int AUG_COLS  = MAX_ORDER + 1;
  localparam int AUG_DEPTH = MAX_ORDER * AUG_COLS;
  localparam int AUG_AW    = $clog2(AUG_DEPTH);
  localparam int FAC_DEPTH = MAX_ORDER * MAX_ORDER;
  localparam int FAC_AW    = $clog2(FAC_DEPTH);
  localparam int VEC_DEPTH = 2 * MAX_ORDER;
  localparam int VEC_AW    = $clog2(VEC_DEPTH);
  localparam int PROD_W    = 2 * DATA_W;
  localparam int RND_W     = PROD_W - FRAC_BITS;
  localparam int ACC_W     = RND_W + CNT_W + 1;
  localparam int NUM_W     = DATA_W + FRAC_BITS;
  localparam int DCNT_W    = $clog2(NUM_W);

  typedef enum logic [3:0] {
    ST_IDLE, ST_INIT, ST_INIT_W, ST_RD, ST_MUL, ST_ACC, ST_FIN,
    ST_PIV, ST_DIV, ST_DQ, ST_WB, ST_OUT_RD, ST_OUT
  } state_t;

  typedef enum logic [1:0] {PH_L, PH_U, PH_FWD, PH_BWD} phase_t;

  function automatic logic [AUG_AW-1:0] aug_addr(input logic [CNT_W-1:0] r,
                                                 input logic [CNT_W-1:0] c);
    return AUG_AW'(int'(r) * AUG_COLS + int'(c));
  endfunction

  function automatic logic [FAC_AW-1:0] fac_addr(input logic [CNT_W-1:0] r,
                                                 input logic [CNT_W-1:0] c);
    return FAC_AW'(int'(r) * MAX_ORDER + int'(c));
  endfunction

  // y lives in the lower half of the vector memory, x in the upper half
  function automatic logic [VEC_AW-1:0] vec_addr(input logic sel_x,
                                                 input logic [CNT_W-1:0] idx);
    return VEC_AW'(int'(idx) + (sel_x ? MAX_ORDER : 0));
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_acc(
      input logic signed [ACC_W-1:0] a);
    logic signed [DATA_W-1:0] r;
    r = a[DATA_W-1:0];
    if (!a[ACC_W-1] && (|a[ACC_W-2:DATA_W-1])) begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (a[ACC_W-1] && !(&a[ACC_W-2:DATA_W-1])) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/lu_solve_ram.sv
// ----------------------------------------------------------------------------
// lu_solve_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module lu_solve_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, then registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/lu_linear_system_solver_top.sv
// ----------------------------------------------------------------------------
// lu_linear_system_solver_top
// Loads an augmented matrix, factors it by Crout LU in Q16.16 and emits x.
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  input     start & !busy           row, column, element, final_element
//  config    cfg_valid & cfg_ready   cfg_data (system order)
//  result    result_valid            unknown_index, solution, singular,
//                                    last_result
//
// Plain words are stored in the augmented memory. A final word starts the
// solve: each computed entry passes through setup, a read, multiply and
// accumulate per product, and write-back; each divided entry (U and y) also
// goes through the bit-serial divider; result words follow. The factor memory
// is held twice so both operands of a product read in the same cycle.
// Reset is synchronous; the order resets to 16. Results cannot be stalled.
`default_nettype none
`include "lu_linear_system_solver_top_defines.svh"
module lu_linear_system_solver_top (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [lu_solve_pkg::ROW_W-1:0]       row,
  input  wire logic [lu_solve_pkg::COL_W-1:0]       column,
  input  wire logic signed [lu_solve_pkg::DATA_W-1:0] element,
  input  wire logic                                 final_element,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [lu_solve_pkg::ORDER_W-1:0]     cfg_data,
  output logic                                      result_valid,
  output logic [lu_solve_pkg::IDX_W-1:0]            unknown_index,
  output logic signed [lu_solve_pkg::DATA_W-1:0]    solution,
  output logic                                      singular,
  output logic                                      last_result
);

  localparam int CW = lu_solve_pkg::CNT_W;
  localparam int DW = lu_solve_pkg::DATA_W;
  localparam int NW = lu_solve_pkg::NUM_W;
  localparam int AW = lu_solve_pkg::ACC_W;
  localparam int RW = lu_solve_pkg::RND_W;
  localparam int PW = lu_solve_pkg::PROD_W;
  localparam int FB = lu_solve_pkg::FRAC_BITS;
  localparam logic [NW-1:0] Q_POS_LIM = {{(NW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic [NW-1:0] Q_NEG_LIM = Q_POS_LIM + NW'(1);
  localparam logic signed [PW-1:0] RND_BIAS = PW'(1) << (FB - 1);

  lu_solve_pkg::state_t state, state_next;
  lu_solve_pkg::phase_t phase, phase_next;
  logic [CW-1:0] i, i_next, j, j_next, k, k_next, klim, klim_next, n, n_next;
  logic [lu_solve_pkg::ORDER_W-1:0] system_order;
  logic signed [AW-1:0] acc, acc_next;
  logic signed [PW-1:0] prod, prod_next;
  logic signed [DW-1:0] wres, wres_next;
  logic [NW-1:0] dvd, dvd_next;
  logic [DW:0] rem, rem_next;
  logic [DW-1:0] dden, dden_next;
  logic dneg, dneg_next;
  logic [lu_solve_pkg::DCNT_W-1:0] dcnt, dcnt_next;
  logic singular_seen, singular_seen_next;

  logic in_acc, aug_we, fac_we, vec_we;
  logic [lu_solve_pkg::AUG_AW-1:0] aug_waddr, aug_raddr;
  logic [lu_solve_pkg::FAC_AW-1:0] fac_waddr, faca_raddr, facb_raddr;
  logic [lu_solve_pkg::VEC_AW-1:0] vec_waddr, vec_raddr;
  logic [DW-1:0] aug_rdata, faca_rdata, facb_rdata, vec_rdata;
  logic signed [DW-1:0] op_b, num32;
  logic [DW-1:0] num_abs, den_abs;
  logic signed [PW-1:0] rnd_sum;
  logic signed [RW-1:0] rnd;
  logic [DW:0] rem_sh;
  logic rem_ge, solve_vec;
  logic [CW-1:0] row_a, col_b;

  assign busy      = (state != lu_solve_pkg::ST_IDLE);
  assign cfg_ready = !busy;
  assign in_acc    = start && !busy;
  assign solve_vec = (phase == lu_solve_pkg::PH_FWD) || (phase == lu_solve_pkg::PH_BWD);

  // store loaded words
  assign aug_we    = in_acc && (int'(row) < lu_solve_pkg::MAX_ORDER)
                     && (int'(column) <= lu_solve_pkg::MAX_ORDER);
  assign aug_waddr = lu_solve_pkg::aug_addr(CW'(row), CW'(column));

  // operand addressing
  assign row_a = (phase == lu_solve_pkg::PH_L) ? j : i;
  assign col_b = (phase == lu_solve_pkg::PH_U) ? j : i;
  assign aug_raddr = (phase == lu_solve_pkg::PH_L) ? lu_solve_pkg::aug_addr(j, i) :
                     (phase == lu_solve_pkg::PH_U) ? lu_solve_pkg::aug_addr(i, j) :
                                                     lu_solve_pkg::aug_addr(i, n);
  assign faca_raddr = (state == lu_solve_pkg::ST_FIN) ? lu_solve_pkg::fac_addr(i, i) :
                                                        lu_solve_pkg::fac_addr(row_a, k);
  assign facb_raddr = lu_solve_pkg::fac_addr(k, col_b);

  always_comb begin
    unique case (state)
      lu_solve_pkg::ST_INIT:   vec_raddr = lu_solve_pkg::vec_addr(1'b0, i);
      lu_solve_pkg::ST_OUT_RD: vec_raddr = lu_solve_pkg::vec_addr(1'b1, i);
      default: vec_raddr = lu_solve_pkg::vec_addr(phase == lu_solve_pkg::PH_BWD, k);
    endcase
  end

  // write-back targets
  assign fac_we    = (state == lu_solve_pkg::ST_WB) && !solve_vec;
  assign fac_waddr = (phase == lu_solve_pkg::PH_L) ? lu_solve_pkg::fac_addr(j, i) :
                                                     lu_solve_pkg::fac_addr(i, j);
  assign vec_we    = (state == lu_solve_pkg::ST_WB) && solve_vec;
  assign vec_waddr = lu_solve_pkg::vec_addr(phase == lu_solve_pkg::PH_BWD, i);

  lu_solve_ram #(.WIDTH(DW), .DEPTH(lu_solve_pkg::AUG_DEPTH)) u_aug_ram (
    .clk(clk), .we(aug_we), .waddr(aug_waddr), .wdata(element),
    .raddr(aug_raddr), .rdata(aug_rdata));
  lu_solve_ram #(.WIDTH(DW), .DEPTH(lu_solve_pkg::FAC_DEPTH)) u_faca_ram (
    .clk(clk), .we(fac_we), .waddr(fac_waddr), .wdata(wres),
    .raddr(faca_raddr), .rdata(faca_rdata));
  lu_solve_ram #(.WIDTH(DW), .DEPTH(lu_solve_pkg::FAC_DEPTH)) u_facb_ram (
    .clk(clk), .we(fac_we), .waddr(fac_waddr), .wdata(wres),
    .raddr(facb_raddr), .rdata(facb_rdata));
  lu_solve_ram #(.WIDTH(DW), .DEPTH(lu_solve_pkg::VEC_DEPTH)) u_vec_ram (
    .clk(clk), .we(vec_we), .waddr(vec_waddr), .wdata(wres),
    .raddr(vec_raddr), .rdata(vec_rdata));

  // datapath helpers
  assign op_b    = solve_vec ? vec_rdata : facb_rdata;
  assign rnd_sum = prod + RND_BIAS;
  assign rnd     = rnd_sum[PW-1:FB];
  assign num32   = lu_solve_pkg::sat_acc(acc);
  assign num_abs = num32[DW-1] ? DW'(-num32) : num32;
  assign den_abs = faca_rdata[DW-1] ? DW'(-faca_rdata) : faca_rdata;
  assign rem_sh  = {rem[DW-1:0], dvd[NW-1]};
  assign rem_ge  = rem_sh >= {1'b0, dden};

  // sequencer
  always_comb begin
    state_next = state;
    phase_next = phase;
    i_next = i;
    j_next = j;
    k_next = k;
    klim_next = klim;
    n_next = n;
    acc_next = acc;
    prod_next = prod;
    wres_next = wres;
    dvd_next = dvd;
    rem_next = rem;
    dden_next = dden;
    dneg_next = dneg;
    dcnt_next = dcnt;
    singular_seen_next = singular_seen;
    unique case (state)
      lu_solve_pkg::ST_IDLE: begin
        if (in_acc && final_element) begin
          if (system_order == '0) begin
            n_next = CW'(1);
          end else if (int'(system_order) > lu_solve_pkg::MAX_ORDER) begin
            n_next = CW'(lu_solve_pkg::MAX_ORDER);
          end else begin
            n_next = CW'(system_order);
          end
          i_next = '0;
          j_next = '0;
          phase_next = lu_solve_pkg::PH_L;
          singular_seen_next = 1'b0;
          state_next = lu_solve_pkg::ST_INIT;
        end
      end
      lu_solve_pkg::ST_INIT: begin
        k_next    = (phase == lu_solve_pkg::PH_BWD) ? i + CW'(1) : '0;
        klim_next = (phase == lu_solve_pkg::PH_BWD) ? n : i;
        state_next = lu_solve_pkg::ST_INIT_W;
      end
      lu_solve_pkg::ST_INIT_W: begin
        acc_next = (phase == lu_solve_pkg::PH_BWD) ? AW'($signed(vec_rdata)) :
                                                     AW'($signed(aug_rdata));
        state_next = (k < klim) ? lu_solve_pkg::ST_RD : lu_solve_pkg::ST_FIN;
      end
      lu_solve_pkg::ST_RD: begin
        state_next = lu_solve_pkg::ST_MUL;
      end
      lu_solve_pkg::ST_MUL: begin
        prod_next = $signed(faca_rdata) * op_b;
        state_next = lu_solve_pkg::ST_ACC;
      end
      lu_solve_pkg::ST_ACC: begin
        acc_next = acc - {{(AW-RW){rnd[RW-1]}}, rnd};
        k_next = k + CW'(1);
        state_next = (k + CW'(1) < klim) ? lu_solve_pkg::ST_RD : lu_solve_pkg::ST_FIN;
      end
      lu_solve_pkg::ST_FIN: begin
        if ((phase == lu_solve_pkg::PH_L) || (phase == lu_solve_pkg::PH_BWD)) begin
          wres_next = num32;
          state_next = lu_solve_pkg::ST_WB;
        end else begin
          state_next = lu_solve_pkg::ST_PIV;
        end
      end
      lu_solve_pkg::ST_PIV: begin
        if (faca_rdata == '0) begin
          wres_next = '0;
          singular_seen_next = 1'b1;
          state_next = lu_solve_pkg::ST_WB;
        end else begin
          dvd_next  = {num_abs, {FB{1'b0}}};
          rem_next  = '0;
          dden_next = den_abs;
          dneg_next = num32[DW-1] ^ faca_rdata[DW-1];
          dcnt_next = '0;
          state_next = lu_solve_pkg::ST_DIV;
        end
      end
      lu_solve_pkg::ST_DIV: begin
        rem_next = rem_ge ? rem_sh - {1'b0, dden} : rem_sh;
        dvd_next = {dvd[NW-2:0], rem_ge};
        dcnt_next = dcnt + 1'b1;
        if (int'(dcnt) == NW - 1) begin
          state_next = lu_solve_pkg::ST_DQ;
        end
      end
      lu_solve_pkg::ST_DQ: begin
        // sign the quotient and saturate
        if (dneg) begin
          wres_next = (dvd > Q_NEG_LIM) ? {1'b1, {(DW-1){1'b0}}} : DW'(-dvd[DW-1:0]);
        end else begin
          wres_next = (dvd > Q_POS_LIM) ? {1'b0, {(DW-1){1'b1}}} : dvd[DW-1:0];
        end
        state_next = lu_solve_pkg::ST_WB;
      end
      lu_solve_pkg::ST_WB: begin
        state_next = lu_solve_pkg::ST_INIT;
        unique case (phase)
          lu_solve_pkg::PH_L: begin
            if (j + CW'(1) < n) begin
              j_next = j + CW'(1);
            end else if (i + CW'(1) < n) begin
              phase_next = lu_solve_pkg::PH_U;
              j_next = i + CW'(1);
            end else begin
              phase_next = lu_solve_pkg::PH_FWD;
              i_next = '0;
            end
          end
          lu_solve_pkg::PH_U: begin
            if (j + CW'(1) < n) begin
              j_next = j + CW'(1);
            end else begin
              phase_next = lu_solve_pkg::PH_L;
              i_next = i + CW'(1);
              j_next = i + CW'(1);
            end
          end
          lu_solve_pkg::PH_FWD: begin
            if (i + CW'(1) < n) begin
              i_next = i + CW'(1);
            end else begin
              phase_next = lu_solve_pkg::PH_BWD;
              i_next = n - CW'(1);
            end
          end
          lu_solve_pkg::PH_BWD: begin
            if (i != '0) begin
              i_next = i - CW'(1);
            end else begin
              state_next = lu_solve_pkg::ST_OUT_RD;
            end
          end
          default: state_next = lu_solve_pkg::ST_IDLE;
        endcase
      end
      lu_solve_pkg::ST_OUT_RD: begin
        state_next = lu_solve_pkg::ST_OUT;
      end
      lu_solve_pkg::ST_OUT: begin
        if (i + CW'(1) < n) begin
          i_next = i + CW'(1);
          state_next = lu_solve_pkg::ST_OUT_RD;
        end else begin
          state_next = lu_solve_pkg::ST_IDLE;
        end
      end
      default: state_next = lu_solve_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lu_solve_pkg::ST_IDLE;
      phase <= lu_solve_pkg::PH_L;
      i <= '0;
      j <= '0;
      k <= '0;
      klim <= '0;
      n <= CW'(lu_solve_pkg::MAX_ORDER);
      dcnt <= '0;
      singular_seen <= 1'b0;
      system_order <= lu_solve_pkg::ORDER_W'(lu_solve_pkg::MAX_ORDER);
    end else begin
      state <= state_next;
      phase <= phase_next;
      i <= i_next;
      j <= j_next;
      k <= k_next;
      klim <= klim_next;
      n <= n_next;
      dcnt <= dcnt_next;
      singular_seen <= singular_seen_next;
      if (cfg_valid && cfg_ready) begin
        system_order <= cfg_data;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    acc <= acc_next;
    prod <= prod_next;
    wres <= wres_next;
    dvd <= dvd_next;
    rem <= rem_next;
    dden <= dden_next;
    dneg <= dneg_next;
  end

  // result word
  assign result_valid  = (state == lu_solve_pkg::ST_OUT);
  assign unknown_index = i[lu_solve_pkg::IDX_W-1:0];
  assign solution      = vec_rdata;
  assign singular      = singular_seen;
  assign last_result   = result_valid && (i + CW'(1) == n);

  `LU_ASSERT_RST(a_rst_idle, clk, rst |=> !busy, "not idle after reset")
  `LU_ASSERT(a_final_busy, clk, rst, (start && !busy && final_element) |=> busy,
             "final word did not start a solve")
  `LU_ASSERT(a_plain_idle, clk, rst, (start && !busy && !final_element) |=> !busy,
             "plain word left the block busy")
  `LU_ASSERT(a_idx_range, clk, rst, busy |-> (i < n), "row index beyond order")
  `LU_ASSERT(a_out_gap, clk, rst, (result_valid && !last_result) |=> !result_valid,
             "result words back to back")

endmodule
`default_nettype wire

>>> bench/tb_lu_linear_system_solver_top.sv
// ----------------------------------------------------------------------------
// tb_lu_linear_system_solver_top
// Self-checking bench for the Crout LU solver: loads augmented matrices word
// by word, starts solves, and checks every emitted unknown against a typed
// answer or an internal fixed-point solver kept alongside the block.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_lu_linear_system_solver_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_WORDS = 75;

  typedef struct {
    logic [lu_solve_pkg::IDX_W-1:0]         idx;
    logic signed [lu_solve_pkg::DATA_W-1:0] value;
    logic                                   sing;
    logic                                   last;
  } answer_t;

  typedef struct {
    bit                                is_cfg;
    logic [lu_solve_pkg::ROW_W-1:0]    r;
    logic [lu_solve_pkg::COL_W-1:0]    c;
    logic [lu_solve_pkg::DATA_W-1:0]   v;
    bit                                fin;
    bit                                typed;
    logic [lu_solve_pkg::DATA_W-1:0]   x_sol;
    bit                                x_sing;
  } vector_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [lu_solve_pkg::ROW_W-1:0] row = '0;
  logic [lu_solve_pkg::COL_W-1:0] column = '0;
  logic signed [lu_solve_pkg::DATA_W-1:0] element = '0;
  logic final_element = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lu_solve_pkg::ORDER_W-1:0] cfg_data = '0;
  logic result_valid;
  logic [lu_solve_pkg::IDX_W-1:0] unknown_index;
  logic signed [lu_solve_pkg::DATA_W-1:0] solution;
  logic singular;
  logic last_result;

  lu_linear_system_solver_top u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .row(row), .column(column), .element(element), .final_element(final_element),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .result_valid(result_valid), .unknown_index(unknown_index),
    .solution(solution), .singular(singular), .last_result(last_result)
  );

  always #5 clk = ~clk;

  // solver shadow state
  int      mat_store [lu_solve_pkg::MAX_ORDER][lu_solve_pkg::AUG_COLS];
  int      lu_store  [lu_solve_pkg::MAX_ORDER][lu_solve_pkg::MAX_ORDER];
  int      y_store   [lu_solve_pkg::MAX_ORDER];
  int      x_store   [lu_solve_pkg::MAX_ORDER];
  bit      pivot_zero;
  logic [lu_solve_pkg::ORDER_W-1:0] order_reg = lu_solve_pkg::ORDER_W'(16);

  answer_t pending_answers[$];
  int      errors = 0;
  int      words_sent = 0;
  int      solves_done = 0;
  int      answers_checked = 0;
  int      idle_pct = 0;
  int      cycles = 0;

  function automatic int sat_word(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  // product rounded to nearest, ties up; arithmetic shift floors
  function automatic longint round_mul(int a, int b);
    longint p;
    p = longint'(a) * longint'(b) + (64'sd1 <<< (lu_solve_pkg::FRAC_BITS - 1));
    return p >>> lu_solve_pkg::FRAC_BITS;
  endfunction

  function automatic int fx_div(longint num, int den);
    longint nn;
    nn = longint'(sat_word(num));
    if (den == 0) begin
      pivot_zero = 1'b1;
      return 0;
    end
    return sat_word((nn <<< lu_solve_pkg::FRAC_BITS) / longint'(den));
  endfunction

  // factor, substitute and queue the emitted unknowns
  task automatic solve_system(bit typed, logic [lu_solve_pkg::DATA_W-1:0] x_sol,
                              bit x_sing);
    int n;
    longint acc;
    answer_t a;
    n = (order_reg == 0) ? 1 :
        (order_reg > lu_solve_pkg::MAX_ORDER) ? lu_solve_pkg::MAX_ORDER : int'(order_reg);
    pivot_zero = 1'b0;
    for (int i = 0; i < n; i++) begin
      for (int j = i; j < n; j++) begin
        acc = mat_store[j][i];
        for (int k = 0; k < i; k++) acc -= round_mul(lu_store[j][k], lu_store[k][i]);
        lu_store[j][i] = sat_word(acc);
      end
      for (int j = i + 1; j < n; j++) begin
        acc = mat_store[i][j];
        for (int k = 0; k < i; k++) acc -= round_mul(lu_store[i][k], lu_store[k][j]);
        lu_store[i][j] = fx_div(acc, lu_store[i][i]);
      end
    end
    for (int i = 0; i < n; i++) begin
      acc = mat_store[i][n];
      for (int j = 0; j < i; j++) acc -= round_mul(lu_store[i][j], y_store[j]);
      y_store[i] = fx_div(acc, lu_store[i][i]);
    end
    for (int i = n - 1; i >= 0; i--) begin
      acc = y_store[i];
      for (int j = i + 1; j < n; j++) acc -= round_mul(lu_store[i][j], x_store[j]);
      x_store[i] = sat_word(acc);
    end
    for (int i = 0; i < n; i++) begin
      a.idx = lu_solve_pkg::IDX_W'(i);
      a.value = typed ? x_sol : x_store[i];
      a.sing = typed ? x_sing : pivot_zero;
      a.last = (i == n - 1);
      pending_answers.push_back(a);
    end
    solves_done++;
  endtask

  // drive one word, hold it until accepted, then maybe idle
  task automatic send_word(logic [lu_solve_pkg::ROW_W-1:0] r,
                           logic [lu_solve_pkg::COL_W-1:0] c,
                           logic [lu_solve_pkg::DATA_W-1:0] v, bit fin,
                           bit typed = 0, logic [lu_solve_pkg::DATA_W-1:0] x_sol = '0,
                           bit x_sing = 0);
    start <= 1'b1;
    row <= r;
    column <= c;
    element <= v;
    final_element <= fin;
    do @(posedge clk); while (busy);
    words_sent++;
    if (c <= lu_solve_pkg::MAX_ORDER) mat_store[r][c] = v;
    if (fin) solve_system(typed, x_sol, x_sing);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // drop start and hold off until every answer has come out
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_order(logic [lu_solve_pkg::ORDER_W-1:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    order_reg = v;
  endtask

  function automatic logic [lu_solve_pkg::DATA_W-1:0] pick_value(int mode, int r, int c,
                                                                 int n);
    int s;
    s = $urandom_range(0, 1) ? 1 : -1;
    case (mode)
      1: return $urandom;
      3: return ($urandom_range(0, 6) - 3) <<< lu_solve_pkg::FRAC_BITS;
      default: begin
        if (c == n) return $urandom_range(0, 1 << 22) - (1 << 21);
        if (c == r) begin
          if (mode == 2 && r == 0) return '0;
          return s * (($urandom_range(2, 8) << lu_solve_pkg::FRAC_BITS) +
                      $urandom_range(0, 65535));
        end
        return $urandom_range(0, 131071) - 65536;
      end
    endcase
  endfunction

  // load a whole matrix in shuffled order with some noise, then solve
  task automatic run_set(logic [lu_solve_pkg::ORDER_W-1:0] ord, int mode);
    int n, cnt, k, t;
    int pr[$], pc[$];
    n = (ord == 0) ? 1 :
        (ord > lu_solve_pkg::MAX_ORDER) ? lu_solve_pkg::MAX_ORDER : int'(ord);
    write_order(ord);
    for (int r = 0; r < n; r++)
      for (int c = 0; c <= n; c++) begin
        pr.push_back(r);
        pc.push_back(c);
      end
    cnt = pr.size();
    for (int i = cnt - 1; i > 0; i--) begin
      k = $urandom_range(0, i);
      t = pr[i]; pr[i] = pr[k]; pr[k] = t;
      t = pc[i]; pc[i] = pc[k]; pc[k] = t;
    end
    for (int i = 0; i < cnt; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        if (n < lu_solve_pkg::MAX_ORDER && $urandom_range(0, 1))
          send_word(lu_solve_pkg::ROW_W'($urandom_range(n, lu_solve_pkg::MAX_ORDER - 1)),
                    lu_solve_pkg::COL_W'($urandom_range(0, 31)), $urandom, 0);
        else
          send_word(lu_solve_pkg::ROW_W'($urandom_range(0, 15)),
                    lu_solve_pkg::COL_W'($urandom_range(17, 31)), $urandom, 0);
      end
      send_word(lu_solve_pkg::ROW_W'(pr[i]), lu_solve_pkg::COL_W'(pc[i]),
                pick_value(mode, pr[i], pc[i], n), 0);
    end
    if ($urandom_range(0, 1)) begin
      k = $urandom_range(0, cnt - 1);
      send_word(lu_solve_pkg::ROW_W'(pr[k]), lu_solve_pkg::COL_W'(pc[k]),
                pick_value(mode, pr[k], pc[k], n), 1);
    end else begin
      send_word(lu_solve_pkg::ROW_W'($urandom_range(0, 15)),
                lu_solve_pkg::COL_W'($urandom_range(17, 31)), $urandom, 1);
    end
  endtask

  // directed vectors: single-unknown extremes typed in, order 2 predicted
  vector_t vectors[21] = '{
    '{1, 0, 0, 32'd1,        0, 0, 0, 0},
    '{0, 0, 0, 32'h00010000, 0, 0, 0, 0},
    '{0, 0, 1, 32'h00030000, 1, 1, 32'h00030000, 0},
    '{0, 0, 0, 32'h00000000, 0, 0, 0, 0},
    '{0, 0, 1, 32'h00050000, 1, 1, 32'h00000000, 1},
    '{0, 0, 0, 32'h00000001, 0, 0, 0, 0},
    '{0, 0, 1, 32'h7FFFFFFF, 1, 1, 32'h7FFFFFFF, 0},
    '{0, 0, 1, 32'h80000000, 1, 1, 32'h80000000, 0},
    '{0, 0, 0, 32'hFFFF0000, 0, 0, 0, 0},
    '{0, 0, 1, 32'h80000000, 1, 1, 32'h7FFFFFFF, 0},
    '{0, 0, 17, 32'h12345678, 0, 0, 0, 0},
    '{0, 15, 31, 32'hFFFFFFFF, 0, 0, 0, 0},
    '{1, 0, 0, 32'd0,        0, 0, 0, 0},
    '{0, 0, 1, 32'h00020000, 1, 1, 32'hFFFE0000, 0},
    '{1, 0, 0, 32'd2,        0, 0, 0, 0},
    '{0, 0, 0, 32'h00020000, 0, 0, 0, 0},
    '{0, 0, 1, 32'h00010000, 0, 0, 0, 0},
    '{0, 1, 0, 32'h00010000, 0, 0, 0, 0},
    '{0, 1, 1, 32'h00030000, 0, 0, 0, 0},
    '{0, 0, 2, 32'h00050000, 0, 0, 0, 0},
    '{0, 1, 2, 32'h000A0000, 1, 0, 0, 0}
  };

  // check each emitted unknown against the oldest pending answer
  always @(posedge clk) begin
    answer_t a;
    if (!rst && result_valid) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected word idx=%0d solution=%h", $time, unknown_index, solution);
        errors++;
      end else begin
        a = pending_answers.pop_front();
        answers_checked++;
        if (unknown_index !== a.idx || solution !== a.value || singular !== a.sing ||
            last_result !== a.last) begin
          $display("%0t: mismatch expected idx=%0d x=%h sing=%b last=%b", $time,
                   a.idx, a.value, a.sing, a.last);
          $display("%0t:          actual   idx=%0d x=%h sing=%b last=%b", $time,
                   unknown_index, solution, singular, last_result);
          errors++;
        end
      end
    end
  end

  // end the run if it hangs
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int phase_start;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    idle_pct = 0;
    foreach (vectors[i]) begin
      if (vectors[i].is_cfg)
        write_order(lu_solve_pkg::ORDER_W'(vectors[i].v));
      else
        send_word(vectors[i].r, vectors[i].c, vectors[i].v, vectors[i].fin,
                  vectors[i].typed, vectors[i].x_sol, vectors[i].x_sing);
    end

    // random part: three idling profiles
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 24 : (ph == 1) ? 50 : 0;
      phase_start = words_sent;
      if (ph == 2) run_set(lu_solve_pkg::ORDER_W'(31), 0);
      while (words_sent - phase_start < PHASE_WORDS) begin
        int p;
        logic [lu_solve_pkg::ORDER_W-1:0] ord;
        p = $urandom_range(0, 99);
        if (p < 4) ord = 0;
        else if (p < 20) ord = lu_solve_pkg::ORDER_W'($urandom_range(5, 8));
        else ord = lu_solve_pkg::ORDER_W'($urandom_range(1, 4));
        run_set(ord, $urandom_range(0, 3));
      end
    end

    wait_idle();
    $display("Sent %0d matrix words over %0d solves, orders 0 to 31 written.",
             words_sent, solves_done);
    $display("Checked %0d unknowns incl. zero pivots and saturation.", answers_checked);
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
